/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sita_pkg.sv */
// shared constants and types for the signed integer to decimal ascii block
`timescale 1ns / 1ps

package sita_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int TAG_WIDTH      = 8;
    localparam int CHAR_WIDTH     = 6;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    // converter status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } sita_conv_status_t;

endpackage

/* hw/rtl/sita_bcd_conv.sv */
// bit-serial binary to bcd converter (shift and add-3)
`timescale 1ns / 1ps

module sita_bcd_conv #(
    parameter int DATA_WIDTH = sita_pkg::DATA_WIDTH_DEF,
    parameter int NUM_DIGITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DATA_WIDTH-1:0]         mag,
    output sita_pkg::sita_conv_status_t   status,
    output logic [NUM_DIGITS*4-1:0]       bcd
);
    import sita_pkg::*;

    localparam int CntW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0]   mag_reg;
    logic [DATA_WIDTH-1:0]   mag_next;
    logic [NUM_DIGITS*4-1:0] bcd_reg;
    logic [NUM_DIGITS*4-1:0] bcd_next;
    logic [NUM_DIGITS*4-1:0] bcd_adj;
    logic [CntW-1:0]         cnt_reg;
    logic [CntW-1:0]         cnt_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = mag;
            bcd_next  = '0;
            cnt_next  = CntW'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[DATA_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[NUM_DIGITS*4-2:0], mag_reg[DATA_WIDTH-1]};
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// top level: signed integer to decimal ascii characters, one word per character
//
//  channel | signals                                                | direction
//  --------+--------------------------------------------------------+-------------
//  in      | in_valid, in_ready, value, dest_tag                    | into block
//  out     | out_valid, out_ready, ascii_char, dest_tag_out, last_char | out of block
//
// one input word at a time: the converter shifts in DATA_WIDTH bits, ST_CONV takes the digits,
// ST_TRIM drops leading zero digits one at a time, ST_SIGN emits a minus when negative, then
// ST_EMIT gives one character per remaining digit; a new word is taken only back in ST_IDLE.
// a stalled output holds the current character and freezes the emit sequence.
// in_ready rises again once the last character sits in the output register.
// reset clears the sequencer, converter control and output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_int_to_decimal_ascii #(
    parameter int DATA_WIDTH = sita_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DATA_WIDTH-1:0]      value,
    input  logic [sita_pkg::TAG_WIDTH-1:0]    dest_tag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sita_pkg::CHAR_WIDTH-1:0]   ascii_char,
    output logic [sita_pkg::TAG_WIDTH-1:0]    dest_tag_out,
    output logic                              last_char
);
    import sita_pkg::*;

    // decimal digits of 2^(DATA_WIDTH-1)
    localparam int NUM_DIGITS = ((DATA_WIDTH - 1) * 301) / 1000 + 1;
    localparam int DigW       = NUM_DIGITS * 4;
    localparam int DCntW      = $clog2(NUM_DIGITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_TRIM = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                neg_reg;
    logic                neg_next;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [TAG_WIDTH-1:0] tag_next;
    logic [DigW-1:0]     dig_reg;
    logic [DigW-1:0]     dig_next;
    logic [DCntW-1:0]    dcnt_reg;
    logic [DCntW-1:0]    dcnt_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CHAR_WIDTH-1:0] char_reg;
    logic [CHAR_WIDTH-1:0] char_next;
    logic [TAG_WIDTH-1:0]  tag_out_reg;
    logic [TAG_WIDTH-1:0]  tag_out_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    logic [DATA_WIDTH-1:0] val_u;
    logic [DATA_WIDTH-1:0] mag;
    logic [3:0]            top_dig;
    sita_conv_status_t     conv_status;
    logic [DigW-1:0]       conv_bcd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign top_dig   = dig_reg[DigW-1 -: 4];

    // magnitude; the most negative value wraps to 2^(DATA_WIDTH-1), still exact unsigned
    assign val_u = value;
    assign mag   = val_u[DATA_WIDTH-1] ? (~val_u + DATA_WIDTH'(1)) : val_u;

    sita_bcd_conv #(
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .mag    (mag),
        .status (conv_status),
        .bcd    (conv_bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        tag_next   = tag_reg;
        dig_next   = dig_reg;
        dcnt_next  = dcnt_reg;
        out_load   = 1'b0;
        char_next  = char_reg;
        last_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next   = val_u[DATA_WIDTH-1];
                    tag_next   = dest_tag;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_status.done)
                begin
                    dig_next   = conv_bcd;
                    dcnt_next  = DCntW'(NUM_DIGITS);
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // drop leading zero digits, keep at least one
                if (top_dig == 4'd0 && dcnt_reg > DCntW'(1))
                begin
                    dig_next  = {dig_reg[DigW-5:0], 4'd0};
                    dcnt_next = dcnt_reg - DCntW'(1);
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = CHAR_MINUS;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    char_next = CHAR_ZERO + {2'b00, top_dig};
                    last_next = (dcnt_reg == DCntW'(1));
                    dig_next  = {dig_reg[DigW-5:0], 4'd0};
                    dcnt_next = dcnt_reg - DCntW'(1);
                    if (dcnt_reg == DCntW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tag_out_next = tag_out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            tag_out_next   = tag_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        tag_reg <= tag_next;
        dig_reg <= dig_next;
        if (out_load)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
        tag_out_reg <= tag_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign ascii_char   = char_reg;
    assign dest_tag_out = tag_out_reg;
    assign last_char    = last_reg;

    `ASSERT_IMPL(a_ready_conv_idle, in_ready, !conv_status.busy, "accept while converter busy")
    `ASSERT_IMPL(a_done_in_conv, conv_status.done, state_reg == ST_CONV, "stray converter done")
    `ASSERT_IMPL(a_emit_has_digit, state_reg == ST_EMIT, dcnt_reg != '0, "emit with no digits")
    `ASSERT_NEXT(a_accept_starts_conv, in_accept, conv_status.busy, "converter not started")

endmodule
